// ----- rtl/core/aca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aca_pkg: shared types and constants of the anticollision cascade assembler
// Opcodes, result kinds, status codes, select codes and the control/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package aca_pkg;

  localparam int unsigned MAX_LEVELS  = 3;
  localparam int unsigned STORE_DEPTH = 10;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  // input opcodes (s_axis_tuser)
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RESP    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result kinds (m_axis_tuser)
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_UID = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RX_ERR  = 2'd1;
  localparam logic [1:0] ST_BCC_ERR = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [7:0] SEL_CL1   = 8'h93;
  localparam logic [7:0] SEL_CL2   = 8'h95;
  localparam logic [7:0] SEL_CL3   = 8'h97;
  localparam logic [7:0] CT_BYTE   = 8'h88;
  localparam logic [7:0] NVB_CODE  = 8'h20;
  localparam logic [5:0] FRAME_LEN = 6'd5;

  // what a latched item turns into
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CMD,
    ACT_ERR,
    ACT_UID
  } act_e;

  typedef struct packed {
    logic latch;   // capture the accepted transaction
    logic apply;   // update sequence state, load single result if any
    logic emit;    // load next identifier byte
  } ctrl_cmd_t;

  typedef struct packed {
    act_e action;
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // current identifier byte is the final one
  } dp_stat_t;

  function automatic logic [7:0] sel_code_f(input logic [1:0] lvl);
    logic [7:0] code;
    unique case (lvl)
      2'd0:    code = SEL_CL1;
      2'd1:    code = SEL_CL2;
      default: code = SEL_CL3;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/anticollision_cascade_uid_assembler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anticollision_cascade_uid_assembler: cascade select and UID assembly
//
//   channel   dir  handshake            tuser      tdata
//   s_axis    in   tvalid/tready        op         rx_ok, rx_count, resp_b0..4
//   m_axis    out  tvalid/tready/tlast  kind       sel_code, nvb, uid_byte,
//                                                  uid_len, status
//
// An input transaction is captured, then decided in the next cycle; a command
// or error result waits while the output register is full, is then loaded
// into the output register and the next transaction is taken. An identifier
// of n bytes (4, 7, 9 or 10) goes out one byte per output slot.
// A stalled m_axis holds the output register and the byte sequencer.
// Reset clears the sequence state; the identifier store needs no clearing.
// ----------------------------------------------------------------------------
module anticollision_cascade_uid_assembler
  import aca_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] op
  input  logic [1:0]             s_axis_tuser,
  // [0] rx_ok, [6:1] rx_count, [14:7] resp_b0, [22:15] resp_b1,
  // [30:23] resp_b2, [38:31] resp_b3, [46:39] resp_b4, [47] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic                   m_axis_tlast,
  // [1:0] kind
  output logic [1:0]             m_axis_tuser,
  // [7:0] sel_code, [15:8] nvb, [23:16] uid_byte, [27:24] uid_len,
  // [29:28] status, [31:30] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [7:0] sel_code, nvb, uid_byte;
  logic [3:0] uid_len;
  logic [1:0] status;

  aca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser),
    .rx_ok_i     (s_axis_tdata[0]),
    .rx_count_i  (s_axis_tdata[6:1]),
    .resp_b0_i   (s_axis_tdata[14:7]),
    .resp_b1_i   (s_axis_tdata[22:15]),
    .resp_b2_i   (s_axis_tdata[30:23]),
    .resp_b3_i   (s_axis_tdata[38:31]),
    .resp_b4_i   (s_axis_tdata[46:39]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .sel_code_o  (sel_code),
    .nvb_o       (nvb),
    .uid_byte_o  (uid_byte),
    .uid_len_o   (uid_len),
    .status_o    (status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, status, uid_len, uid_byte, nvb, sel_code};

endmodule

// ----- rtl/core/aca_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aca_ctrl: sequencing state machine
// Accepts one transaction, has it decided by the datapath, then steps the
// identifier bytes out one per free output slot.
// ----------------------------------------------------------------------------
module aca_ctrl
  import aca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        // capture only on a real handshake
        if (in_valid_i && ready_q) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat_i.action)
          ACT_NONE: begin
            cmd_o.apply = 1'b1;
            state_d     = S_IDLE;
          end
          ACT_UID: begin
            // identifier bytes go out from S_EMIT, store is updated here
            cmd_o.apply = 1'b1;
            state_d     = S_EMIT;
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.apply = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ----- rtl/core/aca_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aca_dp: datapath of the anticollision cascade assembler
// Input capture, frame checks, cascade state, identifier store and the
// output register.
// ----------------------------------------------------------------------------
module aca_dp
  import aca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  input  logic [1:0] op_i,
  input  logic       rx_ok_i,
  input  logic [5:0] rx_count_i,
  input  logic [7:0] resp_b0_i,
  input  logic [7:0] resp_b1_i,
  input  logic [7:0] resp_b2_i,
  input  logic [7:0] resp_b3_i,
  input  logic [7:0] resp_b4_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] sel_code_o,
  output logic [7:0] nvb_o,
  output logic [7:0] uid_byte_o,
  output logic [3:0] uid_len_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  // captured transaction
  logic [1:0] op_q;
  logic       rx_ok_q;
  logic [5:0] rx_count_q;
  logic [7:0] b_q [5];

  // sequence state
  logic       busy_q, busy_d;
  logic [1:0] level_q, level_d;
  logic [3:0] uid_count_q, uid_count_d;
  logic [3:0] emit_idx_q;
  logic [7:0] store_q [STORE_DEPTH];

  // output register
  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] sel_q, nvb_q, uid_q;
  logic [3:0] len_q;
  logic [1:0] status_q;
  logic       last_q;

  act_e       action;
  logic [1:0] err_code;
  logic       frame_good;
  logic       is_tag;
  logic [1:0] level_inc;
  logic [7:0] wr_byte [4];
  logic [2:0] wr_num;
  logic       store_en;
  logic       out_free;
  logic       load_cmd, load_err;
  logic [4:0] count_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= op_i;
      rx_ok_q    <= rx_ok_i;
      rx_count_q <= rx_count_i;
      b_q[0]     <= resp_b0_i;
      b_q[1]     <= resp_b1_i;
      b_q[2]     <= resp_b2_i;
      b_q[3]     <= resp_b3_i;
      b_q[4]     <= resp_b4_i;
    end
  end

  assign is_tag    = (b_q[0] == CT_BYTE);
  assign level_inc = level_q + 2'd1;

  always_comb begin
    action     = ACT_NONE;
    err_code   = ST_OK;
    frame_good = 1'b0;
    if (op_q == OP_START) begin
      action = ACT_CMD;
    end else if (!busy_q || (op_q != OP_RESP && op_q != OP_TIMEOUT)) begin
      action = ACT_NONE;
    end else if (op_q == OP_TIMEOUT) begin
      action   = ACT_ERR;
      err_code = ST_TIMEOUT;
    end else if (!rx_ok_q || rx_count_q != FRAME_LEN) begin
      action   = ACT_ERR;
      err_code = ST_RX_ERR;
    end else if ((b_q[0] ^ b_q[1] ^ b_q[2] ^ b_q[3]) != b_q[4]) begin
      action   = ACT_ERR;
      err_code = ST_BCC_ERR;
    end else begin
      frame_good = 1'b1;
      action = (is_tag && 32'(level_inc) < MAX_LEVELS) ? ACT_CMD : ACT_UID;
    end
  end

  // bytes to store: three after a cascade tag, else all four
  always_comb begin
    if (is_tag) begin
      wr_byte[0] = b_q[1];
      wr_byte[1] = b_q[2];
      wr_byte[2] = b_q[3];
      wr_byte[3] = b_q[3];
      wr_num     = 3'd3;
    end else begin
      wr_byte[0] = b_q[0];
      wr_byte[1] = b_q[1];
      wr_byte[2] = b_q[2];
      wr_byte[3] = b_q[3];
      wr_num     = 3'd4;
    end
  end

  assign store_en  = cmd_i.apply && frame_good;
  assign count_sum = {1'b0, uid_count_q} + {2'b00, wr_num};

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    uid_count_d = uid_count_q;
    if (cmd_i.apply) begin
      if (op_q == OP_START) begin
        busy_d      = 1'b1;
        level_d     = 2'd0;
        uid_count_d = 4'd0;
      end else if (action == ACT_ERR || action == ACT_UID) begin
        busy_d = 1'b0;
      end
      if (store_en) begin
        uid_count_d = (count_sum > 5'(STORE_DEPTH)) ? 4'(STORE_DEPTH) : count_sum[3:0];
        if (is_tag) level_d = level_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= 2'd0;
      uid_count_q <= 4'd0;
      emit_idx_q  <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      level_q     <= level_d;
      uid_count_q <= uid_count_d;
      if (cmd_i.apply)     emit_idx_q <= 4'd0;
      else if (cmd_i.emit) emit_idx_q <= emit_idx_q + 4'd1;
      if (load_cmd || load_err || cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i)                    out_valid_q <= 1'b0;
    end
  end

  // identifier store: up to four sequential entries written per response
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (store_en && 3'(k) < wr_num &&
          ({1'b0, uid_count_q} + 5'(k)) < 5'(STORE_DEPTH)) begin
        store_q[uid_count_q + 4'(k)] <= wr_byte[k];
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign load_cmd = cmd_i.apply && (action == ACT_CMD);
  assign load_err = cmd_i.apply && (action == ACT_ERR);

  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      kind_q   <= KIND_CMD;
      sel_q    <= sel_code_f((op_q == OP_START) ? 2'd0 : level_inc);
      nvb_q    <= NVB_CODE;
      uid_q    <= 8'd0;
      len_q    <= 4'd0;
      status_q <= ST_OK;
      last_q   <= 1'b1;
    end else if (load_err) begin
      kind_q   <= KIND_ERR;
      sel_q    <= 8'd0;
      nvb_q    <= 8'd0;
      uid_q    <= 8'd0;
      len_q    <= 4'd0;
      status_q <= err_code;
      last_q   <= 1'b1;
    end else if (cmd_i.emit) begin
      kind_q   <= KIND_UID;
      sel_q    <= 8'd0;
      nvb_q    <= 8'd0;
      uid_q    <= store_q[emit_idx_q];
      len_q    <= uid_count_q;
      status_q <= ST_OK;
      last_q   <= stat_o.emit_last;
    end
  end

  assign stat_o.action    = action;
  assign stat_o.out_free  = out_free;
  assign stat_o.emit_last = (emit_idx_q == uid_count_q - 4'd1);

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign sel_code_o  = sel_q;
  assign nvb_o       = nvb_q;
  assign uid_byte_o  = uid_q;
  assign uid_len_o   = len_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uid_count_q <= 4'(STORE_DEPTH))
    else $error("identifier count beyond store depth");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (emit_idx_q < uid_count_q))
    else $error("identifier read past stored bytes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_cmd || load_err || cmd_i.emit) |-> out_free)
    else $error("pending result overwritten");

  a_err_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_err || (cmd_i.apply && action == ACT_UID)) |=> !busy_q)
    else $error("sequence still busy after error or identifier");

  a_busy_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (32'(level_q) < MAX_LEVELS))
    else $error("busy beyond last cascade level");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: anticollision_cascade_uid_assembler
// Sends start, response and timeout transactions. Directed cascades of one to
// three levels and every error path come first, then random cascades with
// injected faults and noise, then a long receiver hold-off. A behavioral model
// of the cascade predicts each command, identifier and error result, and every
// output transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
  import aca_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         RANDOM_ITEMS    = 290;

  // same layout as s_axis_tdata, lowest field last
  typedef struct packed {
    logic       pad;
    logic [7:0] b4;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
    logic [5:0] rx_count;
    logic       rx_ok;
  } resp_frame_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] sel_code;
    logic [7:0] nvb;
    logic [7:0] uid_byte;
    logic [3:0] uid_len;
    logic [1:0] status;
    logic       last;
  } uid_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [1:0]             s_axis_tuser  = OP_START;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   m_axis_tlast;
  logic [1:0]             m_axis_tuser;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // cascade model state
  logic       card_active = 1'b0;
  logic [1:0] cascade_lvl = '0;
  logic [7:0] uid_buf [STORE_DEPTH];
  logic [3:0] uid_fill    = '0;

  uid_result_t expected_results [$];
  uid_result_t oldest_expected;

  logic idle_on = 1'b1;
  logic rx_hold = 1'b0;
  event rx_hold_ev;

  int items_sent     = 0;
  int ignored_items  = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int uids_seen      = 0;
  int uid_bytes_seen = 0;
  int cmds_seen      = 0;
  int errors_seen    = 0;

  anticollision_cascade_uid_assembler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // cascade model
  // --------------------------------------------------------------------------
  function automatic void push_result(input logic [1:0] kind, input logic [7:0] sel,
                                      input logic [7:0] nvb, input logic [7:0] ub,
                                      input logic [3:0] len, input logic [1:0] st,
                                      input logic last);
    uid_result_t r;
    r.kind     = kind;
    r.sel_code = sel;
    r.nvb      = nvb;
    r.uid_byte = ub;
    r.uid_len  = len;
    r.status   = st;
    r.last     = last;
    expected_results.push_back(r);
  endfunction

  function automatic void push_select();
    logic [7:0] code;
    case (cascade_lvl)
      2'd0:    code = SEL_CL1;
      2'd1:    code = SEL_CL2;
      default: code = SEL_CL3;
    endcase
    push_result(KIND_CMD, code, NVB_CODE, 8'h00, 4'd0, ST_OK, 1'b1);
  endfunction

  function automatic void push_error(input logic [1:0] st);
    card_active = 1'b0;
    push_result(KIND_ERR, 8'h00, 8'h00, 8'h00, 4'd0, st, 1'b1);
  endfunction

  function automatic void push_uid();
    card_active = 1'b0;
    for (int i = 0; i < int'(uid_fill); i++)
      push_result(KIND_UID, 8'h00, 8'h00, uid_buf[i], uid_fill, ST_OK,
                  i == int'(uid_fill) - 1);
  endfunction

  function automatic void store_uid_byte(input logic [7:0] b);
    if (uid_fill < STORE_DEPTH) begin
      uid_buf[uid_fill] = b;
      uid_fill++;
    end
  endfunction

  // returns the number of results the transaction causes
  function automatic int predict_cascade(input logic [1:0] op, input resp_frame_t f);
    int before_cnt;
    before_cnt = expected_results.size();
    if (op == OP_START) begin
      card_active = 1'b1;
      cascade_lvl = '0;
      uid_fill    = '0;
      push_select();
    end else if (card_active && op != OP_UNUSED) begin
      if (op == OP_TIMEOUT) begin
        push_error(ST_TIMEOUT);
      end else if (!f.rx_ok || f.rx_count != FRAME_LEN) begin
        push_error(ST_RX_ERR);
      end else if ((f.b0 ^ f.b1 ^ f.b2 ^ f.b3) != f.b4) begin
        push_error(ST_BCC_ERR);
      end else if (f.b0 == CT_BYTE) begin
        store_uid_byte(f.b1);
        store_uid_byte(f.b2);
        store_uid_byte(f.b3);
        cascade_lvl = cascade_lvl + 2'd1;
        if (cascade_lvl < MAX_LEVELS) push_select();
        else push_uid();
      end else begin
        store_uid_byte(f.b0);
        store_uid_byte(f.b1);
        store_uid_byte(f.b2);
        store_uid_byte(f.b3);
        push_uid();
      end
    end
    return expected_results.size() - before_cnt;
  endfunction

  // --------------------------------------------------------------------------
  // frame helpers
  // --------------------------------------------------------------------------
  function automatic resp_frame_t good_frame(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    resp_frame_t f;
    f          = '0;
    f.rx_ok    = 1'b1;
    f.rx_count = FRAME_LEN;
    f.b0       = b0;
    f.b1       = b1;
    f.b2       = b2;
    f.b3       = b3;
    f.b4       = b0 ^ b1 ^ b2 ^ b3;
    return f;
  endfunction

  function automatic resp_frame_t tag_frame();
    return good_frame(CT_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
  endfunction

  function automatic resp_frame_t uid_frame();
    logic [7:0] first;
    do first = 8'($urandom_range(255)); while (first == CT_BYTE);
    return good_frame(first, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
  endfunction

  // often well-formed framing so noise also gets past the reception check
  function automatic resp_frame_t noise_frame();
    resp_frame_t f;
    f          = '0;
    f.rx_ok    = ($urandom_range(3) != 0);
    f.rx_count = $urandom_range(1) ? FRAME_LEN : 6'($urandom_range(63));
    f.b0       = $urandom_range(3) == 0 ? CT_BYTE : 8'($urandom_range(255));
    f.b1       = 8'($urandom_range(255));
    f.b2       = 8'($urandom_range(255));
    f.b3       = 8'($urandom_range(255));
    f.b4       = $urandom_range(1) ? (f.b0 ^ f.b1 ^ f.b2 ^ f.b3)
                                   : 8'($urandom_range(255));
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input resp_frame_t frame);
    if (idle_on) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= frame;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_cascade(op, frame) != 0) items_sent++;
    else ignored_items++;
  endtask

  // one start plus 1..3 levels; may inject a fault at a random level
  task automatic send_cascade(input int depth);
    int          fault_at;
    logic        aborted;
    resp_frame_t f;
    fault_at = ($urandom_range(3) == 0) ? $urandom_range(depth - 1) : -1;
    aborted  = 1'b0;
    send_item(OP_START, noise_frame());
    for (int lvl = 0; lvl < depth && !aborted; lvl++) begin
      if (lvl < depth - 1) f = tag_frame();
      else if (depth == MAX_LEVELS && $urandom_range(3) == 0) f = tag_frame();
      else f = uid_frame();
      if (lvl == fault_at) begin
        aborted = 1'b1;
        case ($urandom_range(5))
          0: send_item(OP_TIMEOUT, f);
          1: begin
            f.rx_ok = 1'b0;
            send_item(OP_RESP, f);
          end
          2: begin
            f.rx_count = f.rx_count ^ 6'($urandom_range(1, 63));
            send_item(OP_RESP, f);
          end
          3: begin
            f.b4 = f.b4 ^ 8'($urandom_range(1, 255));
            send_item(OP_RESP, f);
          end
          4: send_item(OP_START, f);
          default: begin
            // unused opcode is dropped, the cascade carries on
            send_item(OP_UNUSED, f);
            aborted = 1'b0;
          end
        endcase
      end
      if (!aborted) send_item(OP_RESP, f);
    end
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else if (idle_on) m_axis_tready <= ($urandom_range(99) >= 19);
    else m_axis_tready <= 1'b1;
  end

  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("ERROR: %s on result %0d: got 0x%0h, expected 0x%0h",
             what, results_seen, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, 32'h0);
      end else begin
        oldest_expected = expected_results.pop_front();
        case (oldest_expected.kind)
          KIND_CMD: cmds_seen++;
          KIND_ERR: errors_seen++;
          default: begin
            uid_bytes_seen++;
            if (oldest_expected.last) uids_seen++;
          end
        endcase
        if (m_axis_tuser !== oldest_expected.kind)
          report_mismatch("kind", 32'(m_axis_tuser), 32'(oldest_expected.kind));
        if (m_axis_tdata[7:0] !== oldest_expected.sel_code)
          report_mismatch("sel_code", 32'(m_axis_tdata[7:0]),
                          32'(oldest_expected.sel_code));
        if (m_axis_tdata[15:8] !== oldest_expected.nvb)
          report_mismatch("nvb", 32'(m_axis_tdata[15:8]), 32'(oldest_expected.nvb));
        if (m_axis_tdata[23:16] !== oldest_expected.uid_byte)
          report_mismatch("uid_byte", 32'(m_axis_tdata[23:16]),
                          32'(oldest_expected.uid_byte));
        if (m_axis_tdata[27:24] !== oldest_expected.uid_len)
          report_mismatch("uid_len", 32'(m_axis_tdata[27:24]),
                          32'(oldest_expected.uid_len));
        if (m_axis_tdata[29:28] !== oldest_expected.status)
          report_mismatch("status", 32'(m_axis_tdata[29:28]),
                          32'(oldest_expected.status));
        if (m_axis_tdata[31:30] !== 2'b00)
          report_mismatch("tdata padding", 32'(m_axis_tdata[31:30]), 32'h0);
        if (m_axis_tlast !== oldest_expected.last)
          report_mismatch("tlast", 32'(m_axis_tlast), 32'(oldest_expected.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_results.size());
      $display("FAIL anticollision_cascade_uid_assembler");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_cascade_levels();
    // single level, all-zero and all-one bytes
    send_item(OP_START, noise_frame());
    send_item(OP_RESP, good_frame(8'h00, 8'hFF, 8'h00, 8'hFF));
    // double level, check byte of 0xFF
    send_item(OP_START, noise_frame());
    send_item(OP_RESP, good_frame(CT_BYTE, 8'hFF, 8'h00, 8'h5A));
    send_item(OP_RESP, good_frame(8'hFF, 8'h00, 8'h00, 8'h00));
    // triple level, 10 bytes
    send_item(OP_START, noise_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_RESP, uid_frame());
    // tag still present at the last level: 9 bytes
    send_item(OP_START, noise_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_RESP, tag_frame());
  endtask

  task automatic test_error_cases();
    resp_frame_t f;
    // idle: dropped
    send_item(OP_RESP, uid_frame());
    send_item(OP_TIMEOUT, noise_frame());
    // bad reception with zero count
    send_item(OP_START, noise_frame());
    f          = uid_frame();
    f.rx_ok    = 1'b0;
    f.rx_count = '0;
    send_item(OP_RESP, f);
    // good reception, full-scale count
    send_item(OP_START, noise_frame());
    f          = uid_frame();
    f.rx_count = 6'h3F;
    send_item(OP_RESP, f);
    // check byte mismatch
    send_item(OP_START, noise_frame());
    f    = uid_frame();
    f.b4 = ~f.b4;
    send_item(OP_RESP, f);
    // timeout while busy
    send_item(OP_START, noise_frame());
    send_item(OP_TIMEOUT, noise_frame());
    // restart mid-cascade, unused opcode while busy
    send_item(OP_START, noise_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_START, noise_frame());
    send_item(OP_UNUSED, uid_frame());
    send_item(OP_RESP, tag_frame());
    send_item(OP_RESP, uid_frame());
  endtask

  task automatic test_random_sequences();
    int stop_at;
    int calm_from;
    int calm_to;
    stop_at   = items_sent + RANDOM_ITEMS;
    calm_from = items_sent + RANDOM_ITEMS / 3;
    calm_to   = calm_from + 80;
    while (items_sent < stop_at) begin
      idle_on <= !(items_sent >= calm_from && items_sent < calm_to);
      if ($urandom_range(99) < 80)
        send_cascade($urandom_range(1, MAX_LEVELS));
      else
        send_item(2'($urandom_range(3)), noise_frame());
    end
  endtask

  task automatic test_output_backpressure();
    -> rx_hold_ev;
    idle_on <= 1'b0;
    repeat (6) begin
      send_item(OP_START, noise_frame());
      send_item(OP_RESP, tag_frame());
      send_item(OP_RESP, tag_frame());
      send_item(OP_RESP, uid_frame());
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cascade_levels();
    test_error_cases();
    test_random_sequences();
    test_output_backpressure();
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d transactions with results and %0d dropped ones (idle or unused op).",
             items_sent, ignored_items);
    $display("Checked %0d results: %0d identifiers (%0d bytes), %0d select commands, %0d errors.",
             results_seen, uids_seen, uid_bytes_seen, cmds_seen, errors_seen);
    if (mismatch_count == 0) begin
      $display("PASS anticollision_cascade_uid_assembler");
    end else begin
      $display("FAIL anticollision_cascade_uid_assembler");
    end
    $finish;
  end

endmodule
